FILE: rtl/obb_pkg.sv
`timescale 1ns / 1ps
package obb_pkg;
    // default field formats
    localparam int OBB_COORD_WIDTH = 16;
    localparam int OBB_AXIS_WIDTH  = 16;
    // cycles from accept to result entering the queue
    localparam int OBB_LAT    = 10;
    // result queue holds every item in flight
    localparam int OBB_QDEPTH = OBB_LAT + 2;
endpackage

FILE: rtl/obb_overlap_test.sv
`timescale 1ns / 1ps
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// box pair  | push / full            | i_first_* and i_second_* (ten fields)
// result    | empty / pop            | o_boxes_overlap
//
// One box pair is taken every cycle while full is low; its result enters the result
// queue at the end of the projection and radius multiply chain.
// Reset clears the in-flight count, the valid pipe and the queue pointers.
// full rises only when OBB_QDEPTH items are accepted and not yet popped, so a
// stalled consumer stops input without losing items in the pipeline.
module obb_overlap_test
    import obb_pkg::*;
#(
    parameter int COORD_WIDTH = OBB_COORD_WIDTH,
    parameter int AXIS_WIDTH  = OBB_AXIS_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [3*COORD_WIDTH-1:0]  i_first_half_lengths,
    input  logic [3*COORD_WIDTH-1:0]  i_first_centre,
    input  logic [3*AXIS_WIDTH-1:0]   i_first_axis_x,
    input  logic [3*AXIS_WIDTH-1:0]   i_first_axis_y,
    input  logic [3*AXIS_WIDTH-1:0]   i_first_axis_z,
    input  logic [3*COORD_WIDTH-1:0]  i_second_half_lengths,
    input  logic [3*COORD_WIDTH-1:0]  i_second_centre,
    input  logic [3*AXIS_WIDTH-1:0]   i_second_axis_x,
    input  logic [3*AXIS_WIDTH-1:0]   i_second_axis_y,
    input  logic [3*AXIS_WIDTH-1:0]   i_second_axis_z,
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_boxes_overlap
);
    localparam int C  = COORD_WIDTH;
    localparam int X  = AXIS_WIDTH;
    localparam int CW = $clog2(OBB_QDEPTH + 1);

    logic [C-1:0]          w_a [3];
    logic [C-1:0]          w_b [3];
    logic signed [C:0]     w_v [3];
    logic signed [X-1:0]   w_ax [3][3];
    logic signed [X-1:0]   w_bx [3][3];
    logic signed [C+X+2:0] w_t [3];
    logic signed [2*X+1:0] w_r [3][3];
    logic signed [2*X:0]   w_l [3][3][3];
    logic                  w_overlap;

    logic [OBB_LAT-1:0]    r_vld;
    logic [CW-1:0]         r_cnt;
    logic                  w_in;
    logic                  w_out;

    assign w_in  = push && !full;
    assign w_out = pop && !empty;
    assign full  = (r_cnt == CW'(OBB_QDEPTH));

    obb_proj #(.C(C), .X(X)) u_proj (
        .i_clk                 (i_clk),
        .i_first_half_lengths  (i_first_half_lengths),
        .i_first_centre        (i_first_centre),
        .i_first_axis_x        (i_first_axis_x),
        .i_first_axis_y        (i_first_axis_y),
        .i_first_axis_z        (i_first_axis_z),
        .i_second_half_lengths (i_second_half_lengths),
        .i_second_centre       (i_second_centre),
        .i_second_axis_x       (i_second_axis_x),
        .i_second_axis_y       (i_second_axis_y),
        .i_second_axis_z       (i_second_axis_z),
        .o_a (w_a), .o_b (w_b), .o_v (w_v), .o_ax (w_ax), .o_bx (w_bx),
        .o_t (w_t), .o_r (w_r), .o_l (w_l)
    );

    obb_sat #(.C(C), .X(X)) u_sat (
        .i_clk (i_clk),
        .i_a (w_a), .i_b (w_b), .i_v (w_v), .i_ax (w_ax), .i_bx (w_bx),
        .i_t (w_t), .i_r (w_r), .i_l (w_l),
        .o_overlap (w_overlap)
    );

    obb_rq #(.DEPTH(OBB_QDEPTH)) u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_vld[OBB_LAT-1]),
        .i_wdata (w_overlap),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (o_boxes_overlap)
    );

    // valid pipe and items-in-flight count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
        end else begin
            r_vld <= {r_vld[OBB_LAT-2:0], w_in};
            r_cnt <= r_cnt + CW'(w_in) - CW'(w_out);
        end
    end

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) <= r_cnt)
        else $error("pipeline holds more items than accepted");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in |=> r_vld[0])
        else $error("accepted item missing from pipeline");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_cnt != '0))
        else $error("result waiting with no item counted");
endmodule

FILE: rtl/obb_mul.sv
`timescale 1ns / 1ps
// signed multiply with registered partial products for the two halves of b, then a registered recombine
module obb_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                        i_clk,
    input  logic signed [AW-1:0]        i_a,
    input  logic signed [BW-1:0]        i_b,
    output logic signed [AW+BW-1:0]     o_p
);
    localparam int H  = BW / 2;
    localparam int HW = BW - H;
    localparam int PW = AW + BW;

    logic signed [AW+H:0]    r_lo;
    logic signed [AW+HW-1:0] r_hi;
    logic signed [PW-1:0]    r_p;

    // partial products
    always_ff @(posedge i_clk) begin
        r_lo <= i_a * $signed({1'b0, i_b[H-1:0]});
        r_hi <= i_a * $signed(i_b[BW-1:H]);
    end

    // recombine
    always_ff @(posedge i_clk) begin
        r_p <= (PW'(r_hi) <<< H) + PW'(r_lo);
    end

    assign o_p = r_p;
endmodule

FILE: rtl/obb_proj.sv
`timescale 1ns / 1ps
// front: unpack boxes, form T = v.A, R = A.B and the nine cross axes L
module obb_proj #(
    parameter int C = 16,
    parameter int X = 16
) (
    input  logic                 i_clk,
    input  logic [3*C-1:0]       i_first_half_lengths,
    input  logic [3*C-1:0]       i_first_centre,
    input  logic [3*X-1:0]       i_first_axis_x,
    input  logic [3*X-1:0]       i_first_axis_y,
    input  logic [3*X-1:0]       i_first_axis_z,
    input  logic [3*C-1:0]       i_second_half_lengths,
    input  logic [3*C-1:0]       i_second_centre,
    input  logic [3*X-1:0]       i_second_axis_x,
    input  logic [3*X-1:0]       i_second_axis_y,
    input  logic [3*X-1:0]       i_second_axis_z,
    output logic [C-1:0]         o_a [3],
    output logic [C-1:0]         o_b [3],
    output logic signed [C:0]    o_v [3],
    output logic signed [X-1:0]  o_ax [3][3],
    output logic signed [X-1:0]  o_bx [3][3],
    output logic signed [C+X+2:0] o_t [3],
    output logic signed [2*X+1:0] o_r [3][3],
    output logic signed [2*X:0]   o_l [3][3][3]
);
    localparam int VW = C + 1;
    localparam int TW = C + X + 3;
    localparam int RW = 2 * X + 2;
    localparam int LW = 2 * X + 1;
    localparam int PV = VW + X;
    localparam int PA = 2 * X;

    logic [C-1:0]         u_a [3];
    logic [C-1:0]         u_b [3];
    logic signed [VW-1:0] u_v [3];
    logic signed [X-1:0]  u_ax [3][3];
    logic signed [X-1:0]  u_bx [3][3];

    logic [C-1:0]         r1_a [3];
    logic [C-1:0]         r1_b [3];
    logic signed [VW-1:0] r1_v [3];
    logic signed [X-1:0]  r1_ax [3][3];
    logic signed [X-1:0]  r1_bx [3][3];

    logic [C-1:0]         r2_a [3];
    logic [C-1:0]         r2_b [3];
    logic signed [VW-1:0] r2_v [3];
    logic signed [X-1:0]  r2_ax [3][3];
    logic signed [X-1:0]  r2_bx [3][3];
    logic signed [PV-1:0] r2_pv [3][3];
    logic signed [PA-1:0] r2_pr [3][3][3];
    logic signed [PA-1:0] r2_pl [3][3][6];

    logic [C-1:0]         r3_a [3];
    logic [C-1:0]         r3_b [3];
    logic signed [VW-1:0] r3_v [3];
    logic signed [X-1:0]  r3_ax [3][3];
    logic signed [X-1:0]  r3_bx [3][3];
    logic signed [TW-1:0] r3_t [3];
    logic signed [RW-1:0] r3_r [3][3];
    logic signed [LW-1:0] r3_l [3][3][3];

    // unpack, offset in world frame
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_a[i] = i_first_half_lengths[i*C +: C];
            u_b[i] = i_second_half_lengths[i*C +: C];
            u_v[i] = $signed({i_second_centre[i*C+C-1], i_second_centre[i*C +: C]})
                   - $signed({i_first_centre[i*C+C-1], i_first_centre[i*C +: C]});
            u_ax[0][i] = i_first_axis_x[i*X +: X];
            u_ax[1][i] = i_first_axis_y[i*X +: X];
            u_ax[2][i] = i_first_axis_z[i*X +: X];
            u_bx[0][i] = i_second_axis_x[i*X +: X];
            u_bx[1][i] = i_second_axis_y[i*X +: X];
            u_bx[2][i] = i_second_axis_z[i*X +: X];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a  <= u_a;
        r1_b  <= u_b;
        r1_v  <= u_v;
        r1_ax <= u_ax;
        r1_bx <= u_bx;
    end

    // component products
    always_ff @(posedge i_clk) begin
        r2_a  <= r1_a;
        r2_b  <= r1_b;
        r2_v  <= r1_v;
        r2_ax <= r1_ax;
        r2_bx <= r1_bx;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r2_pv[i][j] <= r1_v[j] * r1_ax[i][j];
            end
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_pr[i][k][j] <= r1_ax[i][j] * r1_bx[k][j];
                end
                r2_pl[i][k][0] <= r1_ax[i][1] * r1_bx[k][2];
                r2_pl[i][k][1] <= r1_ax[i][2] * r1_bx[k][1];
                r2_pl[i][k][2] <= r1_ax[i][2] * r1_bx[k][0];
                r2_pl[i][k][3] <= r1_ax[i][0] * r1_bx[k][2];
                r2_pl[i][k][4] <= r1_ax[i][0] * r1_bx[k][1];
                r2_pl[i][k][5] <= r1_ax[i][1] * r1_bx[k][0];
            end
        end
    end

    // sums: T, R, cross axes
    always_ff @(posedge i_clk) begin
        r3_a  <= r2_a;
        r3_b  <= r2_b;
        r3_v  <= r2_v;
        r3_ax <= r2_ax;
        r3_bx <= r2_bx;
        for (int i = 0; i < 3; i++) begin
            r3_t[i] <= TW'(r2_pv[i][0]) + TW'(r2_pv[i][1]) + TW'(r2_pv[i][2]);
            for (int k = 0; k < 3; k++) begin
                r3_r[i][k] <= RW'(r2_pr[i][k][0]) + RW'(r2_pr[i][k][1])
                            + RW'(r2_pr[i][k][2]);
                r3_l[i][k][0] <= LW'(r2_pl[i][k][0]) - LW'(r2_pl[i][k][1]);
                r3_l[i][k][1] <= LW'(r2_pl[i][k][2]) - LW'(r2_pl[i][k][3]);
                r3_l[i][k][2] <= LW'(r2_pl[i][k][4]) - LW'(r2_pl[i][k][5]);
            end
        end
    end

    assign o_a  = r3_a;
    assign o_b  = r3_b;
    assign o_v  = r3_v;
    assign o_ax = r3_ax;
    assign o_bx = r3_bx;
    assign o_t  = r3_t;
    assign o_r  = r3_r;
    assign o_l  = r3_l;
endmodule

FILE: rtl/obb_sat.sv
`timescale 1ns / 1ps
// back: the 15 axis tests on the projections
module obb_sat #(
    parameter int C = 16,
    parameter int X = 16
) (
    input  logic                  i_clk,
    input  logic [C-1:0]          i_a [3],
    input  logic [C-1:0]          i_b [3],
    input  logic signed [C:0]     i_v [3],
    input  logic signed [X-1:0]   i_ax [3][3],
    input  logic signed [X-1:0]   i_bx [3][3],
    input  logic signed [C+X+2:0] i_t [3],
    input  logic signed [2*X+1:0] i_r [3][3],
    input  logic signed [2*X:0]   i_l [3][3][3],
    output logic                  o_overlap
);
    localparam int F  = X - 2;
    localparam int VW = C + 1;
    localparam int TW = C + X + 3;
    localparam int RW = 2 * X + 2;
    localparam int LW = 2 * X + 1;
    localparam int DW = X + LW + 2;
    localparam int W  = C + 3 * X + 8;

    function automatic logic [W-1:0] f_abs(input logic signed [W-1:0] x);
        return x[W-1] ? W'(-x) : W'(x);
    endfunction

    // products from the split multipliers
    logic signed [VW+RW-1:0] m_fb [3][3];
    logic signed [TW+RW-1:0] m_ft [3][3];
    logic signed [VW+RW-1:0] m_fa [3][3];
    logic signed [VW+LW-1:0] m_cv [3][3][3];
    logic signed [X+LW-1:0]  m_da [3][3][3][3];
    logic signed [X+LW-1:0]  m_db [3][3][3][3];
    logic signed [VW+DW-1:0] m_ma [3][3][3];
    logic signed [VW+DW-1:0] m_mb [3][3][3];

    logic [C-1:0]         r4_a [3];
    logic [C-1:0]         r4_b [3];
    logic signed [TW-1:0] r4_t [3];
    logic [C-1:0]         r5_a [3];
    logic [C-1:0]         r5_b [3];
    logic signed [TW-1:0] r5_t [3];
    logic [C-1:0]         r6_a [3];
    logic [C-1:0]         r6_b [3];

    logic [W-1:0]         r6_tl1 [3];
    logic [W-1:0]         r6_rr1 [3];
    logic [W-1:0]         r6_tl2 [3];
    logic [W-1:0]         r6_rr2 [3];
    logic [W-1:0]         r6_ctl [3][3];
    logic signed [DW-1:0] r6_da [3][3][3];
    logic signed [DW-1:0] r6_db [3][3][3];

    logic                 r7_face;
    logic [W-1:0]         r7_ctl [3][3];
    logic                 r8_face;
    logic [W-1:0]         r8_ctl [3][3];
    logic                 r9_face;
    logic [W-1:0]         r9_ctl [3][3];
    logic [W-1:0]         r9_crr [3][3];
    logic                 r10_sep;
    logic                 w_face;
    logic                 w_csep;

    // first multiply rank, fed by the projections
    for (genvar i = 0; i < 3; i++) begin : g_i
        for (genvar k = 0; k < 3; k++) begin : g_k
            obb_mul #(.AW(VW), .BW(RW)) u_fb (
                .i_clk(i_clk), .i_a($signed({1'b0, i_b[k]})), .i_b(i_r[i][k]),
                .o_p(m_fb[i][k]));
            obb_mul #(.AW(TW), .BW(RW)) u_ft (
                .i_clk(i_clk), .i_a(i_t[i]), .i_b(i_r[i][k]), .o_p(m_ft[i][k]));
            obb_mul #(.AW(VW), .BW(RW)) u_fa (
                .i_clk(i_clk), .i_a($signed({1'b0, i_a[i]})), .i_b(i_r[i][k]),
                .o_p(m_fa[i][k]));
            for (genvar j = 0; j < 3; j++) begin : g_j
                obb_mul #(.AW(VW), .BW(LW)) u_cv (
                    .i_clk(i_clk), .i_a(i_v[j]), .i_b(i_l[i][k][j]),
                    .o_p(m_cv[i][k][j]));
                // second rank: radii on the cross axis
                obb_mul #(.AW(VW), .BW(DW)) u_ma (
                    .i_clk(i_clk), .i_a($signed({1'b0, r6_a[j]})), .i_b(r6_da[i][k][j]),
                    .o_p(m_ma[i][k][j]));
                obb_mul #(.AW(VW), .BW(DW)) u_mb (
                    .i_clk(i_clk), .i_a($signed({1'b0, r6_b[j]})), .i_b(r6_db[i][k][j]),
                    .o_p(m_mb[i][k][j]));
                for (genvar m = 0; m < 3; m++) begin : g_m
                    obb_mul #(.AW(X), .BW(LW)) u_da (
                        .i_clk(i_clk), .i_a(i_ax[j][m]), .i_b(i_l[i][k][m]),
                        .o_p(m_da[i][k][j][m]));
                    obb_mul #(.AW(X), .BW(LW)) u_db (
                        .i_clk(i_clk), .i_a(i_bx[j][m]), .i_b(i_l[i][k][m]),
                        .o_p(m_db[i][k][j][m]));
                end
            end
        end
    end

    // carry half lengths and T alongside the multipliers
    always_ff @(posedge i_clk) begin
        r4_a <= i_a;
        r4_b <= i_b;
        r4_t <= i_t;
        r5_a <= r4_a;
        r5_b <= r4_b;
        r5_t <= r4_t;
        r6_a <= r5_a;
        r6_b <= r5_b;
    end

    // face sides, cross offsets and cross dot products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r6_tl1[i] <= f_abs(W'(r5_t[i])) << F;
            r6_rr1[i] <= (W'(r5_a[i]) << (2 * F)) + f_abs(W'(m_fb[i][0]))
                       + f_abs(W'(m_fb[i][1])) + f_abs(W'(m_fb[i][2]));
            r6_tl2[i] <= f_abs(W'(m_ft[0][i]) + W'(m_ft[1][i]) + W'(m_ft[2][i]));
            r6_rr2[i] <= ((f_abs(W'(m_fa[0][i])) + f_abs(W'(m_fa[1][i]))
                       + f_abs(W'(m_fa[2][i]))) << F) + (W'(r5_b[i]) << (3 * F));
            for (int k = 0; k < 3; k++) begin
                r6_ctl[i][k] <= f_abs(W'(m_cv[i][k][0]) + W'(m_cv[i][k][1])
                              + W'(m_cv[i][k][2])) << F;
                for (int j = 0; j < 3; j++) begin
                    r6_da[i][k][j] <= DW'(m_da[i][k][j][0]) + DW'(m_da[i][k][j][1])
                                    + DW'(m_da[i][k][j][2]);
                    r6_db[i][k][j] <= DW'(m_db[i][k][j][0]) + DW'(m_db[i][k][j][1])
                                    + DW'(m_db[i][k][j][2]);
                end
            end
        end
    end

    // any face axis separates
    always_comb begin
        w_face = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if ((r6_tl1[i] > r6_rr1[i]) || (r6_tl2[i] > r6_rr2[i])) begin
                w_face = 1'b1;
            end
        end
    end

    // face compares, cross offsets wait for their radii
    always_ff @(posedge i_clk) begin
        r7_face <= w_face;
        r7_ctl  <= r6_ctl;
        r8_face <= r7_face;
        r8_ctl  <= r7_ctl;
    end

    // cross radii
    always_ff @(posedge i_clk) begin
        r9_face <= r8_face;
        r9_ctl  <= r8_ctl;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                r9_crr[i][k] <= f_abs(W'(m_ma[i][k][0])) + f_abs(W'(m_ma[i][k][1]))
                              + f_abs(W'(m_ma[i][k][2])) + f_abs(W'(m_mb[i][k][0]))
                              + f_abs(W'(m_mb[i][k][1])) + f_abs(W'(m_mb[i][k][2]));
            end
        end
    end

    // any cross axis separates
    always_comb begin
        w_csep = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                if (r9_ctl[i][k] > r9_crr[i][k]) begin
                    w_csep = 1'b1;
                end
            end
        end
    end

    // final verdict
    always_ff @(posedge i_clk) begin
        r10_sep <= r9_face || w_csep;
    end

    assign o_overlap = ~r10_sep;
endmodule

FILE: rtl/obb_rq.sv
`timescale 1ns / 1ps
// result queue, one bit per item
module obb_rq #(
    parameter int DEPTH = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  logic i_wdata,
    input  logic i_rd,
    output logic o_empty,
    output logic o_rdata
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_rd;

    assign w_rd = i_rd && (r_cnt != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_wr) - CW'(w_rd);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
endmodule

FILE: verif/obb_overlap_test_test.sv
`timescale 1ns / 1ps
module obb_overlap_test_test;
    import obb_pkg::*;

    localparam int CW = OBB_COORD_WIDTH;
    localparam int AW = OBB_AXIS_WIDTH;
    localparam int ONE_SHIFT = AW - 2;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [3*CW-1:0] a_half;
        logic [3*CW-1:0] a_ctr;
        logic [3*AW-1:0] a_ax [3];
        logic [3*CW-1:0] b_half;
        logic [3*CW-1:0] b_ctr;
        logic [3*AW-1:0] b_ax [3];
    } box_pair_t;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    logic [3*CW-1:0] i_first_half_lengths, i_first_centre;
    logic [3*AW-1:0] i_first_axis_x, i_first_axis_y, i_first_axis_z;
    logic [3*CW-1:0] i_second_half_lengths, i_second_centre;
    logic [3*AW-1:0] i_second_axis_x, i_second_axis_y, i_second_axis_z;
    logic empty;
    logic pop;
    logic o_boxes_overlap;

    logic expected_overlap [$];
    int   error_count;
    longint cycle_count;
    bit   hold_pop;
    int   checked_count;

    obb_overlap_test dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic longint s_val(input logic [63:0] f, input int i, input int w);
        logic [63:0] u;
        u = (f >> (i * w)) & ((64'd1 << w) - 1);
        if (u[w-1]) return longint'(u) - (longint'(1) << w);
        return longint'(u);
    endfunction

    function automatic longint u_val(input logic [63:0] f, input int i, input int w);
        return longint'((f >> (i * w)) & ((64'd1 << w) - 1));
    endfunction

    function automatic wide_t wabs(input wide_t x);
        return x < 0 ? -x : x;
    endfunction

    // separating axis prediction over all 15 axes
    function automatic logic predict_overlap(input box_pair_t p);
        longint a[3], b[3], v[3], ta[3];
        longint am[3][3], bm[3][3], rm[3][3], l[3];
        wide_t one, tl, rr;
        bit sep;
        one = wide_t'(1) <<< ONE_SHIFT;
        sep = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = u_val(p.a_half, i, CW);
            b[i] = u_val(p.b_half, i, CW);
            v[i] = s_val(p.b_ctr, i, CW) - s_val(p.a_ctr, i, CW);
            for (int j = 0; j < 3; j++) begin
                am[i][j] = s_val(p.a_ax[i], j, AW);
                bm[i][j] = s_val(p.b_ax[i], j, AW);
            end
        end
        for (int i = 0; i < 3; i++) begin
            ta[i] = v[0]*am[i][0] + v[1]*am[i][1] + v[2]*am[i][2];
            for (int k = 0; k < 3; k++)
                rm[i][k] = am[i][0]*bm[k][0] + am[i][1]*bm[k][1] + am[i][2]*bm[k][2];
        end
        // face axes of box one
        for (int i = 0; i < 3; i++) begin
            tl = wabs(wide_t'(ta[i]) * one);
            rr = wide_t'(a[i]) * one * one;
            for (int k = 0; k < 3; k++) rr += wabs(wide_t'(b[k]) * wide_t'(rm[i][k]));
            if (tl > rr) sep = 1;
        end
        // face axes of box two
        for (int k = 0; k < 3; k++) begin
            tl = 0;
            rr = wide_t'(b[k]) * one * one * one;
            for (int i = 0; i < 3; i++) begin
                tl += wide_t'(ta[i]) * wide_t'(rm[i][k]);
                rr += wabs(wide_t'(a[i]) * one * wide_t'(rm[i][k]));
            end
            if (wabs(tl) > rr) sep = 1;
        end
        // edge cross axes
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                l[0] = am[i][1]*bm[k][2] - am[i][2]*bm[k][1];
                l[1] = am[i][2]*bm[k][0] - am[i][0]*bm[k][2];
                l[2] = am[i][0]*bm[k][1] - am[i][1]*bm[k][0];
                tl = 0;
                rr = 0;
                for (int j = 0; j < 3; j++) begin
                    tl += wide_t'(v[j]) * one * wide_t'(l[j]);
                    rr += wabs(wide_t'(a[j]) * wide_t'(am[j][0]*l[0] + am[j][1]*l[1]
                          + am[j][2]*l[2]));
                    rr += wabs(wide_t'(b[j]) * wide_t'(bm[j][0]*l[0] + bm[j][1]*l[1]
                          + bm[j][2]*l[2]));
                end
                if (wabs(tl) > rr) sep = 1;
            end
        return !sep;
    endfunction

    // send one box pair after a random gap; push stays up when the next item follows
    task automatic send_pair(input box_pair_t p);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push                  <= 1'b1;
        i_first_half_lengths  <= p.a_half;
        i_first_centre        <= p.a_ctr;
        i_first_axis_x        <= p.a_ax[0];
        i_first_axis_y        <= p.a_ax[1];
        i_first_axis_z        <= p.a_ax[2];
        i_second_half_lengths <= p.b_half;
        i_second_centre       <= p.b_ctr;
        i_second_axis_x       <= p.b_ax[0];
        i_second_axis_y       <= p.b_ax[1];
        i_second_axis_z       <= p.b_ax[2];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_overlap.push_back(predict_overlap(p));
    endtask

    // result consumer with random stalls
    initial begin
        int gap;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0 || hold_pop) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (hold_pop) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (expected_overlap.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                if (o_boxes_overlap !== expected_overlap[0])
                    report_mismatch($sformatf("overlap got %b want %b",
                        o_boxes_overlap, expected_overlap[0]));
                void'(expected_overlap.pop_front());
            end
            checked_count++;
        end
    end

    function automatic logic [3*AW-1:0] pack_axis(input int x, input int y, input int z);
        return {AW'(z), AW'(y), AW'(x)};
    endfunction

    function automatic logic [3*CW-1:0] pack_coord(input int x, input int y, input int z);
        return {CW'(z), CW'(y), CW'(x)};
    endfunction

    function automatic box_pair_t aligned_pair(input int dx, input int h);
        box_pair_t p;
        int one;
        one = 1 << ONE_SHIFT;
        p.a_half = pack_coord(h, h, h);
        p.b_half = pack_coord(h, h, h);
        p.a_ctr = '0;
        p.b_ctr = pack_coord(dx, 0, 0);
        p.a_ax[0] = pack_axis(one, 0, 0);
        p.a_ax[1] = pack_axis(0, one, 0);
        p.a_ax[2] = pack_axis(0, 0, one);
        p.b_ax = p.a_ax;
        return p;
    endfunction

    function automatic box_pair_t random_pair(input bit unit_axes);
        box_pair_t p;
        int one, sx, sy;
        int perm;
        one = 1 << ONE_SHIFT;
        p.a_half = pack_coord($urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(0, 2047));
        p.b_half = pack_coord($urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(0, 2047));
        p.a_ctr = pack_coord($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                             $urandom_range(0, 4095) - 2048);
        p.b_ctr = pack_coord($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                             $urandom_range(0, 4095) - 2048);
        if (unit_axes) begin
            // rotated frames: a cyclic shift of the axes plus a rotation in one plane
            for (int s = 0; s < 2; s++) begin
                sx = $urandom_range(0, one);
                sy = $urandom_range(0, one - sx);
                perm = $urandom_range(0, 2);
                if (s == 0) begin
                    p.a_ax[perm]         = pack_axis(one - sy, sy, 0);
                    p.a_ax[(perm+1) % 3] = pack_axis(-sy, one - sy, 0);
                    p.a_ax[(perm+2) % 3] = pack_axis(0, 0, ($urandom_range(0, 1)) ? one : -one);
                end else begin
                    p.b_ax[perm]         = pack_axis(one - sx, 0, sx);
                    p.b_ax[(perm+1) % 3] = pack_axis(0, ($urandom_range(0, 1)) ? one : -one, 0);
                    p.b_ax[(perm+2) % 3] = pack_axis(-sx, 0, one - sx);
                end
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                p.a_ax[i] = (3*AW)'({$urandom, $urandom});
                p.b_ax[i] = (3*AW)'({$urandom, $urandom});
            end
            p.a_half = (3*CW)'({$urandom, $urandom});
            p.b_half = (3*CW)'({$urandom, $urandom});
            p.a_ctr = (3*CW)'({$urandom, $urandom});
            p.b_ctr = (3*CW)'({$urandom, $urandom});
        end
        return p;
    endfunction

    // field extremes, touching, separated and parallel boxes
    task automatic test_directed();
        box_pair_t p;
        int h;
        h = 256;
        send_pair(aligned_pair(2 * h, h));
        send_pair(aligned_pair(2 * h + 1, h));
        send_pair(aligned_pair(-2 * h, h));
        send_pair(aligned_pair(-2 * h - 1, h));
        send_pair(aligned_pair(0, 0));
        send_pair(aligned_pair(1, 0));
        p = aligned_pair(0, 0);
        p.a_half = '1; p.b_half = '1;
        send_pair(p);
        p.a_ctr = pack_coord(32767, 32767, 32767);
        p.b_ctr = pack_coord(-32768, -32768, -32768);
        send_pair(p);
        p.a_half = '0; p.b_half = '0;
        send_pair(p);
        for (int i = 0; i < 3; i++) begin
            p.a_ax[i] = '1; p.b_ax[i] = '0;
        end
        send_pair(p);
        for (int i = 0; i < 3; i++) begin
            p.a_ax[i] = {3{1'b1, {(AW-1){1'b0}}}};
            p.b_ax[i] = {3{1'b0, {(AW-1){1'b1}}}};
        end
        send_pair(p);
        p.a_half = '1; p.b_half = '1;
        send_pair(p);
        p.a_ctr = '0; p.b_ctr = '0;
        send_pair(p);
        for (int n = 0; n < 8; n++) send_pair(random_pair(n[0]));
    endtask

    // mixed random stream
    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            send_pair(random_pair($urandom_range(0, 3) != 0));
    endtask

    // consumer halts long enough to fill the result queue
    task automatic test_backpressure();
        hold_pop = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_pop = 1'b0;
            end
            test_random(60);
        join
    endtask

    initial begin
        push = 1'b0;
        hold_pop = 1'b0;
        error_count = 0;
        checked_count = 0;
        cycle_count = 0;
        i_first_half_lengths = '0; i_first_centre = '0;
        i_first_axis_x = '0; i_first_axis_y = '0; i_first_axis_z = '0;
        i_second_half_lengths = '0; i_second_centre = '0;
        i_second_axis_x = '0; i_second_axis_y = '0; i_second_axis_z = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1720);
        push <= 1'b0;
        while (expected_overlap.size() != 0) @(posedge i_clk);
        repeat (OBB_LAT + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: obb_overlap_test.f
rtl/obb_pkg.sv
rtl/obb_mul.sv
rtl/obb_proj.sv
rtl/obb_sat.sv
rtl/obb_rq.sv
rtl/obb_overlap_test.sv
verif/obb_overlap_test_test.sv
